/* sv/afcp_pkg.sv */
// Package of the ASCII field to CAN packer: transaction types, field phase enum,
// frame layout constants and character class helpers. No dependencies.
package afcp_pkg;

	// Configuration and field widths.
	localparam int unsigned ID_W      = 11;
	localparam int unsigned DLC_W     = 4;
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned VALUE_W   = 16;
	localparam int unsigned ACC_W     = 17;
	localparam int unsigned PAYLOAD_W = 64;
	localparam int unsigned PACK_W    = 48;

	// Frame layout.
	localparam int unsigned MAX_FIELDS     = 32;
	localparam int unsigned MAX_FRAME      = 1024;
	localparam int unsigned HEADER_LEN     = 12;
	localparam int unsigned MAGIC_LEN      = 3;
	localparam int unsigned FIELD_CHARS    = 5;
	localparam int unsigned VALUES_PER_CAN = 4;
	localparam int unsigned FULL_DLC       = 8;

	localparam int unsigned POS_W   = $clog2(MAX_FRAME + 1);
	localparam int unsigned FCNT_W  = $clog2(MAX_FIELDS + 1);
	localparam int unsigned CHAR_W  = $clog2(FIELD_CHARS);
	localparam int unsigned VIP_W   = $clog2(VALUES_PER_CAN);

	localparam logic [ID_W-1:0] BASE_ID_RESET = ID_W'(11'h0BC);

	// Header magic characters.
	localparam logic [BYTE_W-1:0] MAGIC_0 = 8'h41;
	localparam logic [BYTE_W-1:0] MAGIC_1 = 8'h72;
	localparam logic [BYTE_W-1:0] MAGIC_2 = 8'h64;

	localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;
	localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;
	localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
	localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;

	// Progress through one decimal field.
	typedef enum logic [1:0] {
		PHASE_SKIP   = 2'd0,
		PHASE_DIGITS = 2'd1,
		PHASE_DONE   = 2'd2
	} field_phase_t;

	// One received serial byte.
	typedef struct packed {
		logic [BYTE_W-1:0] rx_byte;
		logic              frame_end;
	} in_item_t;

	// One CAN data frame.
	typedef struct packed {
		logic [ID_W-1:0]      can_id;
		logic [DLC_W-1:0]     dlc;
		logic [PAYLOAD_W-1:0] payload;
	} out_item_t;

	function automatic logic is_space(input logic [BYTE_W-1:0] c);
		return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
	endfunction

	function automatic logic is_digit(input logic [BYTE_W-1:0] c);
		return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
	endfunction

	function automatic logic [BYTE_W-1:0] magic_char(input logic [1:0] p);
		logic [BYTE_W-1:0] c;
		case (p)
			2'd0: c = MAGIC_0;
			2'd1: c = MAGIC_1;
			default: c = MAGIC_2;
		endcase
		return c;
	endfunction

endpackage

/* sv/ascii_field_to_can_packer_top.sv */
// Top level of the ASCII field to CAN packer: input register, frame logic and
// output register. Depends on afcp_pkg and afcp_core.
//
// Usage:
// Serial bytes of a frame enter on in_valid/in_ready/in_item, one per
// transaction, with frame_end set on the last byte. Frames that open with
// "Ard" are parsed from byte 12 on as 5-character decimal fields; every four
// values leave as one CAN frame on out_valid/out_ready/out_item (DLC 8), and
// a remainder leaves at frame end with DLC twice its count.
// base_id is written over cfg_valid/cfg_ready/cfg_data (cfg_ready is registered
// and rises out of reset) and takes effect from the next serial frame.
// Path: each byte passes from the input register through the frame logic into
// the output register, which raises out_valid. Throughput: one byte per cycle
// while the receiver does not stall, set by the per-byte step between the two.
// While the receiver stalls, the result holds in the output register and one
// further byte is taken into the input register; in_ready then drops until
// the result is taken.
// Reset clears both registers and the frame state, and base_id returns to
// 0xBC. There is no clearing pass after reset.
module ascii_field_to_can_packer_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  afcp_pkg::in_item_t            in_item,
	output logic                          out_valid,
	input  logic                          out_ready,
	output afcp_pkg::out_item_t           out_item,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [afcp_pkg::ID_W-1:0]     cfg_data
);

	logic                       base_id_q;
	logic [afcp_pkg::ID_W-1:0]  base_q;
	logic                       valid_s1;
	afcp_pkg::in_item_t         item_s1;
	logic                       advance;
	logic                       emit;
	afcp_pkg::out_item_t        result;
	logic                       out_valid_q;
	afcp_pkg::out_item_t        out_q;

	assign cfg_ready = base_id_q;
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// Configuration register; the port's ready is registered and stays high once out of reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_id_q <= 1'b0;
			base_q    <= afcp_pkg::BASE_ID_RESET;
		end else begin
			base_id_q <= 1'b1;
			if (cfg_valid && base_id_q) begin
				base_q <= cfg_data;
			end
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	afcp_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.base_id (base_q),
		.advance (advance),
		.item    (item_s1),
		.emit    (emit),
		.result  (result)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_q <= result;
		end
	end

endmodule

/* sv/afcp_core.sv */
// Frame state and per-byte logic of the ASCII field to CAN packer: header check,
// decimal field parsing and grouping into CAN frames. Depends on afcp_pkg.
module afcp_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [afcp_pkg::ID_W-1:0]     base_id,
	input  logic                          advance,
	input  afcp_pkg::in_item_t            item,
	output logic                          emit,
	output afcp_pkg::out_item_t           result
);

	logic [afcp_pkg::POS_W-1:0]   pos_q, pos_d;
	logic                         hdr_q, hdr_d;
	logic [afcp_pkg::CHAR_W-1:0]  cif_q, cif_d;
	afcp_pkg::field_phase_t       phase_q, phase_d;
	logic                         neg_q, neg_d;
	logic [afcp_pkg::ACC_W-1:0]   acc_q, acc_d;
	logic [afcp_pkg::PACK_W-1:0]  pack_q, pack_d;
	logic [afcp_pkg::VIP_W-1:0]   vip_q, vip_d;
	logic [afcp_pkg::FCNT_W-1:0]  fcnt_q, fcnt_d;
	logic [afcp_pkg::ID_W-1:0]    nid_q, nid_d, id_cur;

	logic [afcp_pkg::BYTE_W-1:0]  b;
	logic [afcp_pkg::ACC_W-1:0]   digit;
	logic [afcp_pkg::VALUE_W-1:0] v;

	assign b     = item.rx_byte;
	assign digit = afcp_pkg::ACC_W'(b - afcp_pkg::CHAR_ZERO);

	// Next frame state and the result, if any, for the byte in hand.
	always_comb begin
		pos_d   = pos_q;
		hdr_d   = hdr_q;
		cif_d   = cif_q;
		phase_d = phase_q;
		neg_d   = neg_q;
		acc_d   = acc_q;
		pack_d  = pack_q;
		vip_d   = vip_q;
		fcnt_d  = fcnt_q;
		emit    = 1'b0;
		result  = '0;
		v       = '0;
		id_cur  = (pos_q == '0) ? base_id : nid_q;

		if (pos_q < afcp_pkg::POS_W'(afcp_pkg::MAX_FRAME)) begin
			if (pos_q < afcp_pkg::POS_W'(afcp_pkg::MAGIC_LEN)) begin
				if (b != afcp_pkg::magic_char(pos_q[1:0])) begin
					hdr_d = 1'b0;
				end
			end else if (pos_q >= afcp_pkg::POS_W'(afcp_pkg::HEADER_LEN) && hdr_q) begin
				// Character step of the decimal reader.
				case (phase_q)
					afcp_pkg::PHASE_SKIP: begin
						if (!afcp_pkg::is_space(b)) begin
							if (b == afcp_pkg::CHAR_PLUS || b == afcp_pkg::CHAR_MINUS) begin
								neg_d   = (b == afcp_pkg::CHAR_MINUS);
								phase_d = afcp_pkg::PHASE_DIGITS;
							end else if (afcp_pkg::is_digit(b)) begin
								acc_d   = digit;
								phase_d = afcp_pkg::PHASE_DIGITS;
							end else begin
								phase_d = afcp_pkg::PHASE_DONE;
							end
						end
					end
					afcp_pkg::PHASE_DIGITS: begin
						if (afcp_pkg::is_digit(b)) begin
							acc_d = (acc_q << 3) + (acc_q << 1) + digit;
						end else begin
							phase_d = afcp_pkg::PHASE_DONE;
						end
					end
					default: begin
					end
				endcase

				// Field complete: store its value or send a full group, unless the field limit is reached.
				if (cif_q >= afcp_pkg::CHAR_W'(afcp_pkg::FIELD_CHARS - 1)) begin
					if (fcnt_q < afcp_pkg::FCNT_W'(afcp_pkg::MAX_FIELDS)) begin
						v      = neg_d ? afcp_pkg::VALUE_W'(-acc_d) : acc_d[afcp_pkg::VALUE_W-1:0];
						fcnt_d = fcnt_q + 1'b1;
						if (vip_q == afcp_pkg::VIP_W'(afcp_pkg::VALUES_PER_CAN - 1)) begin
							emit           = 1'b1;
							result.can_id  = id_cur;
							result.dlc     = afcp_pkg::DLC_W'(afcp_pkg::FULL_DLC);
							result.payload = {v, pack_q};
							pack_d         = '0;
							vip_d          = '0;
						end else begin
							case (vip_q)
								2'd0: pack_d[15:0]  = v;
								2'd1: pack_d[31:16] = v;
								default: pack_d[47:32] = v;
							endcase
							vip_d = vip_q + 1'b1;
						end
					end
					cif_d   = '0;
					phase_d = afcp_pkg::PHASE_SKIP;
					neg_d   = 1'b0;
					acc_d   = '0;
				end else begin
					cif_d = cif_q + 1'b1;
				end
			end
			pos_d = pos_q + 1'b1;
		end

		// End of frame: flush the remainder and start afresh.
		if (item.frame_end) begin
			if (hdr_d && vip_d != '0 && !emit) begin
				emit           = 1'b1;
				result.can_id  = id_cur;
				result.dlc     = afcp_pkg::DLC_W'({vip_d, 1'b0});
				result.payload = {16'h0000, pack_d};
			end
			pos_d   = '0;
			hdr_d   = 1'b1;
			cif_d   = '0;
			phase_d = afcp_pkg::PHASE_SKIP;
			neg_d   = 1'b0;
			acc_d   = '0;
			pack_d  = '0;
			vip_d   = '0;
			fcnt_d  = '0;
			nid_d   = base_id;
		end else begin
			nid_d = emit ? id_cur + 1'b1 : id_cur;
		end
	end

	// Frame state registers, updated once per processed byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			hdr_q   <= 1'b1;
			cif_q   <= '0;
			phase_q <= afcp_pkg::PHASE_SKIP;
			neg_q   <= 1'b0;
			acc_q   <= '0;
			pack_q  <= '0;
			vip_q   <= '0;
			fcnt_q  <= '0;
			nid_q   <= afcp_pkg::BASE_ID_RESET;
		end else if (advance) begin
			pos_q   <= pos_d;
			hdr_q   <= hdr_d;
			cif_q   <= cif_d;
			phase_q <= phase_d;
			neg_q   <= neg_d;
			acc_q   <= acc_d;
			pack_q  <= pack_d;
			vip_q   <= vip_d;
			fcnt_q  <= fcnt_d;
			nid_q   <= nid_d;
		end
	end

endmodule

/* sv/afcp_checker.sv */
// Port checker for the ASCII field to CAN packer, with its bind to the top level.
// Depends on afcp_pkg and ascii_field_to_can_packer_top.
module afcp_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input afcp_pkg::out_item_t out_item
);

	// A stalled result holds its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("output transaction changed while stalled");

	// Only full groups or remainders of one to three values are sent.
	a_dlc_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.dlc == 4'd8 || out_item.dlc == 4'd6 ||
			out_item.dlc == 4'd4 || out_item.dlc == 4'd2))
		else $error("illegal DLC");

	// Bytes beyond the DLC are zero.
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.dlc != 4'd8 |->
			out_item.payload[63:48] == 16'h0000 &&
			(out_item.dlc != 4'd2 || out_item.payload[47:16] == 32'h0) &&
			(out_item.dlc != 4'd4 || out_item.payload[47:32] == 16'h0000))
		else $error("payload padding not zero");

	// A stalled receiver with a byte already waiting blocks further input.
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready && $past(in_valid && in_ready) && $past(out_valid)
			|-> !in_ready)
		else $error("input taken while both registers are full");

endmodule

bind ascii_field_to_can_packer_top afcp_checker u_afcp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);

/* verif/ascii_field_to_can_packer_top_tb.sv */
// Self-checking testbench for ascii_field_to_can_packer_top: serial frames in, CAN frames out,
// checked against a behavioural predictor. Depends on afcp_pkg and the RTL top level only.
module ascii_field_to_can_packer_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import afcp_pkg::*;

	localparam int    CYCLE_LIMIT  = 1000000;
	localparam int    DRAIN_CYCLES = 8;
	localparam int    RANDOM_ITEMS = 500;
	localparam string HDR          = "Ard.........";
	// In the directed frames this character stands for a NUL byte.
	localparam byte   NUL_MARK     = "^";

	logic            clk;
	logic            arst_n    = 1'b0;
	logic            in_valid  = 1'b0;
	logic            in_ready;
	in_item_t        in_item   = '0;
	logic            out_valid;
	logic            out_ready = 1'b0;
	out_item_t       out_item;
	logic            cfg_valid = 1'b0;
	logic            cfg_ready;
	logic [ID_W-1:0] cfg_data  = '0;

	ascii_field_to_can_packer_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// One directed serial frame, with an optional base_id write before it.
	typedef struct {
		bit              cfg_write;
		logic [ID_W-1:0] base;
		string           text;
		bit              typed;
		out_item_t       exp;
	} frame_row_t;

	frame_row_t  frame_rows[$];
	out_item_t   can_frames_due[$];
	logic [7:0]  frame_buf[$];
	int          errors       = 0;
	int          random_items = 0;
	int          cycles       = 0;
	bit          idle_on      = 1'b1;

	// Predictor state.
	logic [ID_W-1:0]    base_id_shadow;
	int                 frame_pos;
	bit                 header_ok;
	int                 field_char;
	field_phase_t       phase;
	bit                 is_neg;
	logic [ACC_W-1:0]   dec_acc;
	logic [PACK_W-1:0]  pack_words;
	int                 words_held;
	int                 fields_taken;
	logic [ID_W-1:0]    id_next;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Timeout guard.
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("end of test: mismatches");
		$finish;
	end

	task automatic restart_field();
		field_char = 0;
		phase      = PHASE_SKIP;
		is_neg     = 1'b0;
		dec_acc    = '0;
	endtask

	task automatic restart_frame();
		frame_pos    = 0;
		header_ok    = 1'b1;
		restart_field();
		pack_words   = '0;
		words_held   = 0;
		fields_taken = 0;
		id_next      = base_id_shadow;
	endtask

	// Works out the CAN frame, if any, that one received byte causes.
	task automatic pack_byte(input in_item_t it, output bit sent, output out_item_t frame);
		logic [7:0]         c;
		logic [VALUE_W-1:0] v;
		bit                 sp;
		bit                 dg;
		c     = it.rx_byte;
		sent  = 1'b0;
		frame = '0;
		sp    = (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
		dg    = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
		if (frame_pos == 0)
			id_next = base_id_shadow;
		if (frame_pos < MAX_FRAME) begin
			if (frame_pos < MAGIC_LEN) begin
				if ((frame_pos == 0 && c != MAGIC_0) || (frame_pos == 1 && c != MAGIC_1) ||
				    (frame_pos == 2 && c != MAGIC_2))
					header_ok = 1'b0;
			end else if (frame_pos >= HEADER_LEN && header_ok) begin
				// Decimal field reader: blanks, then an optional sign, then digits.
				case (phase)
					PHASE_SKIP: begin
						if (!sp) begin
							if (c == CHAR_PLUS || c == CHAR_MINUS) begin
								is_neg = (c == CHAR_MINUS);
								phase  = PHASE_DIGITS;
							end else if (dg) begin
								dec_acc = ACC_W'(c - CHAR_ZERO);
								phase   = PHASE_DIGITS;
							end else begin
								phase = PHASE_DONE;
							end
						end
					end
					PHASE_DIGITS: begin
						if (dg)
							dec_acc = ACC_W'(dec_acc * 10 + (c - CHAR_ZERO));
						else
							phase = PHASE_DONE;
					end
					default: ;
				endcase
				// The fifth character closes the field.
				if (field_char == FIELD_CHARS - 1) begin
					if (fields_taken < MAX_FIELDS) begin
						v = is_neg ? VALUE_W'(ACC_W'(0) - dec_acc) : dec_acc[VALUE_W-1:0];
						fields_taken++;
						if (words_held == VALUES_PER_CAN - 1) begin
							frame.can_id  = id_next;
							frame.dlc     = DLC_W'(FULL_DLC);
							frame.payload = {v, pack_words};
							sent          = 1'b1;
							id_next++;
							pack_words    = '0;
							words_held    = 0;
						end else begin
							pack_words[VALUE_W*words_held +: VALUE_W] = v;
							words_held++;
						end
					end
					restart_field();
				end else begin
					field_char++;
				end
			end
			frame_pos++;
		end
		// At frame end any remainder leaves, unless a full group has just gone.
		if (it.frame_end) begin
			if (header_ok && words_held > 0 && !sent) begin
				frame.can_id  = id_next;
				frame.dlc     = DLC_W'(2 * words_held);
				frame.payload = {{VALUE_W{1'b0}}, pack_words};
				sent          = 1'b1;
				id_next++;
			end
			restart_frame();
		end
	endtask

	// Gap lengths: mostly none or short, a few long.
	function automatic int pick_gap();
		int r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Sends one byte transaction and records the CAN frame it should cause.
	task automatic push_byte(input in_item_t it, input bit use_typed, input out_item_t typed_exp);
		int        gap;
		bit        sent;
		out_item_t frame;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		do @(posedge clk); while (!in_ready);
		pack_byte(it, sent, frame);
		if (use_typed)
			can_frames_due.push_back(typed_exp);
		else if (sent)
			can_frames_due.push_back(frame);
	endtask

	// Lets the block go quiet: input off, every expected frame out, then a drain wait.
	task automatic settle();
		in_valid <= 1'b0;
		while (can_frames_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_base(input logic [ID_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		base_id_shadow = v;
	endtask

	task automatic add_row(input bit cfg_write, input logic [ID_W-1:0] base, input string text,
	                       input bit typed, input out_item_t exp);
		frame_row_t row;
		row.cfg_write = cfg_write;
		row.base      = base;
		row.text      = text;
		row.typed     = typed;
		row.exp       = exp;
		frame_rows.push_back(row);
	endtask

	function automatic string repeat_field(input string s, input int n);
		string r;
		r = "";
		repeat (n) r = {r, s};
		return r;
	endfunction

	function automatic logic [7:0] space_char();
		int r;
		r = $urandom_range(0, 5);
		return (r == 0) ? CHAR_SPACE : 8'(CHAR_TAB + r - 1);
	endfunction

	// Appends one 5-character field, mostly well formed with random content.
	task automatic add_field();
		int n;
		int k;
		int r;
		n = 0;
		if ($urandom_range(0, 9) == 0) begin
			repeat (FIELD_CHARS) frame_buf.push_back(8'($urandom));
		end else begin
			k = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
			repeat (k) begin
				frame_buf.push_back(space_char());
				n++;
			end
			if ($urandom_range(0, 2) == 0) begin
				frame_buf.push_back($urandom_range(0, 1) ? CHAR_MINUS : CHAR_PLUS);
				n++;
			end
			k = ($urandom_range(0, 3) != 0) ? FIELD_CHARS - n : $urandom_range(0, FIELD_CHARS - n);
			repeat (k) begin
				frame_buf.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
				n++;
			end
			while (n < FIELD_CHARS) begin
				r = $urandom_range(0, 3);
				if (r < 2)
					frame_buf.push_back(space_char());
				else if (r == 2)
					frame_buf.push_back(8'h00);
				else
					frame_buf.push_back(8'($urandom));
				n++;
			end
		end
	endtask

	// Builds one random serial frame: noise, bad header or good header.
	task automatic build_frame();
		int r;
		int n;
		frame_buf.delete();
		r = $urandom_range(0, 99);
		if (r < 12) begin
			n = $urandom_range(1, 30);
			repeat (n) frame_buf.push_back(8'($urandom));
		end else begin
			frame_buf.push_back(MAGIC_0);
			frame_buf.push_back(MAGIC_1);
			frame_buf.push_back(MAGIC_2);
			if (r < 25)
				frame_buf[$urandom_range(0, 2)] = 8'($urandom);
			repeat (HEADER_LEN - MAGIC_LEN) frame_buf.push_back(8'($urandom));
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 12);
			repeat (n) add_field();
			if ($urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, FIELD_CHARS - 1);
				repeat (n) frame_buf.push_back($urandom_range(0, 1) ?
				                               8'(CHAR_ZERO + $urandom_range(0, 9)) : 8'($urandom));
			end
		end
	endtask

	// Output checker: each CAN frame against the oldest expected one.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (can_frames_due.size() == 0) begin
				errors++;
				$display("%0t: CAN frame with none expected: id=%h dlc=%0d payload=%h",
				         $time, out_item.can_id, out_item.dlc, out_item.payload);
			end else begin
				want = can_frames_due.pop_front();
				if (out_item.can_id !== want.can_id) begin
					errors++;
					$display("%0t: can_id expected %h actual %h", $time, want.can_id,
					         out_item.can_id);
				end
				if (out_item.dlc !== want.dlc) begin
					errors++;
					$display("%0t: dlc expected %0d actual %0d", $time, want.dlc, out_item.dlc);
				end
				if (out_item.payload !== want.payload) begin
					errors++;
					$display("%0t: payload expected %h actual %h", $time, want.payload,
					         out_item.payload);
				end
			end
		end
	end

	// Receiver stalls: random runs of ready and not ready.
	initial begin
		int stall;
		@(posedge clk);
		forever begin
			stall = pick_gap();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	// Stimulus: directed frames, then random frames in phases with base_id writes.
	initial begin
		in_item_t it;
		int       len;
		int       phase_len;
		int       frames_in_phase;
		int       r;

		base_id_shadow = BASE_ID_RESET;
		restart_frame();

		// Values at the extremes, signs, blanks and full groups.
		add_row(0, '0, {HDR, "65535"}, 1, '{can_id: 11'h0BC, dlc: 4'd2, payload: 64'hFFFF});
		add_row(0, '0, {HDR, "  -2 "}, 1, '{can_id: 11'h0BC, dlc: 4'd2, payload: 64'hFFFE});
		add_row(0, '0, {HDR, "   12+0042-0   99999"}, 1,
		        '{can_id: 11'h0BC, dlc: 4'd8, payload: 64'h869F_0000_002A_000C});
		// Empty and malformed fields, then a trailing partial one.
		add_row(0, '0, {HDR, "     +    x1234  -  1"}, 0, '0);
		// Bad header and a frame too short for its header.
		add_row(0, '0, {"ArD.........", "00007"}, 0, '0);
		add_row(0, '0, "Ar", 0, '0);
		// A NUL byte ends the digits of its field.
		add_row(0, '0, {HDR, "12^34", "00005"}, 1,
		        '{can_id: 11'h0BC, dlc: 4'd4, payload: 64'h0005_000C});
		add_row(0, '0, {HDR, "00001", "00002", "0003"}, 1,
		        '{can_id: 11'h0BC, dlc: 4'd4, payload: 64'h0002_0001});
		add_row(0, '0, {HDR, "1    2    3    "}, 1,
		        '{can_id: 11'h0BC, dlc: 4'd6, payload: 64'h0003_0002_0001});
		// Every whitespace character before the digits.
		add_row(0, '0, {HDR, "\011\012\013\0159", "\014 -12"}, 1,
		        '{can_id: 11'h0BC, dlc: 4'd4, payload: 64'hFFF4_0009});
		add_row(0, '0, HDR, 0, '0);
		// Highest base: the identifier wraps within the frame.
		add_row(1, 11'h7FF, {HDR, "    1    2    3    4    5"}, 0, '0);
		add_row(1, 11'h000, {HDR, "32767", "32768"}, 1,
		        '{can_id: 11'h000, dlc: 4'd4, payload: 64'h8000_7FFF});
		// Fields past the limit are dropped; bytes past the frame limit are ignored.
		add_row(0, '0, {HDR, repeat_field("-0002", MAX_FIELDS + 3)}, 0, '0);
		add_row(0, '0, {HDR, repeat_field("    5", 218)}, 0, '0);
		add_row(1, 11'h0BC, {HDR, "00009"}, 1, '{can_id: 11'h0BC, dlc: 4'd2, payload: 64'h9});

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (frame_rows[k]) begin
			if (frame_rows[k].cfg_write) begin
				settle();
				write_base(frame_rows[k].base);
			end
			len = frame_rows[k].text.len();
			for (int i = 0; i < len; i++) begin
				it.rx_byte   = (frame_rows[k].text[i] == NUL_MARK) ? 8'h00 : frame_rows[k].text[i];
				it.frame_end = (i == len - 1);
				push_byte(it, frame_rows[k].typed && (i == len - 1), frame_rows[k].exp);
			end
		end

		// Random frames, in phases separated by idle base_id writes.
		phase_len       = 0;
		frames_in_phase = 0;
		while (random_items < RANDOM_ITEMS) begin
			if (frames_in_phase == phase_len) begin
				settle();
				r = $urandom_range(0, 3);
				write_base((r == 0) ? 11'h000 : (r == 1) ? 11'h7FF : ID_W'($urandom));
				idle_on         = ($urandom_range(0, 3) != 0);
				phase_len       = $urandom_range(2, 6);
				frames_in_phase = 0;
			end
			build_frame();
			foreach (frame_buf[i]) begin
				it.rx_byte   = frame_buf[i];
				it.frame_end = (i == frame_buf.size() - 1);
				push_byte(it, 1'b0, '0);
				random_items++;
			end
			frames_in_phase++;
		end

		settle();
		if (errors == 0 && can_frames_due.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
